// ===== hw/rtl/lsr_pkg.sv =====
// Shared constants and types for the LRU recency stack.
package lsr_pkg;

	localparam int MAX_WAYS = 8;
	localparam int WAY_W    = 3;
	localparam int CFG_W    = 4;
	localparam int FILL_W   = $clog2(MAX_WAYS + 1);
	localparam int CNT_W    = (FILL_W > CFG_W) ? FILL_W : CFG_W;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 8;

	typedef logic [WAY_W-1:0] way_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic adv;
		logic hit;
		logic full;
		cnt_t fill;
		way_t way;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/lsr_cell.sv =====
// One stack position: holds a way, matches it and shifts from the neighbor above.
module lsr_cell (
	input  logic              clk,
	input  lsr_pkg::cell_ctrl_t ctrl,
	input  lsr_pkg::cnt_t     idx,
	input  lsr_pkg::way_t     upper_entry,
	input  logic              above_in,
	output lsr_pkg::way_t     entry,
	output lsr_pkg::way_t     entry_d,
	output logic              match_out
);
	import lsr_pkg::*;

	way_t entry_q;
	logic live;
	logic my_match;
	logic shift;
	logic load_way;

	assign live      = idx < ctrl.fill;
	assign my_match  = live && (entry_q == ctrl.way);
	assign match_out = above_in | my_match;

	always_comb begin
		shift    = ((idx + cnt_t'(1)) < ctrl.fill) &&
		           ((!ctrl.hit && ctrl.full) || (ctrl.hit && !above_in));
		load_way = ((idx + cnt_t'(1)) == ctrl.fill && (ctrl.hit || ctrl.full)) ||
		           (idx == ctrl.fill && !ctrl.hit && !ctrl.full);
		if (shift) begin
			entry_d = upper_entry;
		end else if (load_way) begin
			entry_d = ctrl.way;
		end else begin
			entry_d = entry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

endmodule

// ===== hw/rtl/lru_stack_replacement.sv =====
// Top level of the LRU recency stack: cell chain, fill count and result register.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata[2:0] accessed_way
//  m_*      out  m_tvalid/m_tready  m_tdata[2:0] lru_way, m_tuser was_present
//  cfg_*    in   cfg_we             cfg_wdata ways_in_use
//
// One item per cycle while the output register is not stalled; all cells compare and shift in the same cycle.
// The result appears in the output register in the cycle after acceptance.
// Reset clears the fill count and sets ways_in_use to 8; entries are not cleared.
// s_tready stays high while the output register is empty or being taken.
module lru_stack_replacement (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lsr_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lsr_pkg::IN_TDATA_W-1:0]      s_tdata,   // [2:0] accessed_way
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lsr_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [2:0] lru_way
	output logic                                m_tuser    // [0] was_present
);
	import lsr_pkg::*;

	logic [CFG_W-1:0] ways_q;
	cnt_t             filled_q;
	cnt_t             depth;
	cnt_t             fill_eff;
	cell_ctrl_t       ctrl;
	logic             accept;
	logic             out_valid_q;
	way_t             lru_q;
	logic             hit_q;

	way_t entry   [MAX_WAYS];
	way_t entry_d [MAX_WAYS];
	logic above   [MAX_WAYS+1];

	always_comb begin
		if (ways_q == '0) begin
			depth = cnt_t'(1);
		end else if (cnt_t'(ways_q) > cnt_t'(MAX_WAYS)) begin
			depth = cnt_t'(MAX_WAYS);
		end else begin
			depth = cnt_t'(ways_q);
		end
		fill_eff = (filled_q > depth) ? depth : filled_q;
	end

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;

	assign ctrl.adv  = accept;
	assign ctrl.hit  = above[0];
	assign ctrl.full = (fill_eff == depth);
	assign ctrl.fill = fill_eff;
	assign ctrl.way  = s_tdata[WAY_W-1:0];

	assign above[MAX_WAYS] = 1'b0;

	for (genvar j = 0; j < MAX_WAYS; j++) begin : g_cell
		way_t upper;
		if (j == MAX_WAYS - 1) begin : g_top
			assign upper = '0;
		end else begin : g_mid
			assign upper = entry[j+1];
		end
		lsr_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.idx         (cnt_t'(j)),
			.upper_entry (upper),
			.above_in    (above[j+1]),
			.entry       (entry[j]),
			.entry_d     (entry_d[j]),
			.match_out   (above[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q      <= CFG_W'(8);
			filled_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ways_q <= cfg_wdata;
			end
			if (accept) begin
				filled_q    <= (!ctrl.hit && !ctrl.full) ? fill_eff + cnt_t'(1) : fill_eff;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lru_q <= entry_d[0];
			hit_q <= ctrl.hit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(lru_q);
	assign m_tuser  = hit_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= cnt_t'(MAX_WAYS))
		else $error("fill count beyond stack depth");

	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> filled_q != '0)
		else $error("stack empty after an item");

	a_hit_keeps_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctrl.hit) |=> filled_q == $past(fill_eff))
		else $error("hit changed fill count");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid && m_tuser == $past(ctrl.hit))
		else $error("result missing after item");

endmodule
